>>> rtl/dtp_pkg.sv
// Shared types and constants for the DER identifier-and-length header parser.
`timescale 1ns / 1ps
`default_nettype none

package dtp_pkg;

    // Identifier byte: low five bits all ones announce a high tag number
    localparam logic [4:0] TAG_HIGH_ESCAPE = 5'h1F;

    // Depth of the queue between the decoder and the result stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // One finished header as the decoder hands it on, before the clamp
    typedef struct packed {
        logic        failed;
        logic [31:0] tag_number;
        logic [1:0]  tag_class;
        logic        is_constructed;
        logic        len_big;       // decoded length has bits above 15 set
        logic [15:0] len_low;       // low 16 bits of the decoded length
        logic [15:0] remaining;     // bytes left after the header
    } hdr_event_t;

    // One result request as it leaves the block
    typedef struct packed {
        logic [31:0] tag_number;
        logic [1:0]  tag_class;
        logic        is_constructed;
        logic [15:0] content_length;
        logic        failed;
    } hdr_result_t;

    // Status of the event queue
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

`default_nettype wire

>>> rtl/dtp_front.sv
// Byte-wise decoder for the identifier and length octets of a DER header.
`timescale 1ns / 1ps
`default_nettype none

module dtp_front
    import dtp_pkg::*;
#(
    parameter int TAG_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] bytes_left,
    input  wire logic        restart,
    output logic             evt_valid,
    output hdr_event_t       evt
);

    // Decoder phases
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_TAG_MORE  = 2'd1;
    localparam logic [1:0] PH_LEN_FIRST = 2'd2;
    localparam logic [1:0] PH_LEN_MORE  = 2'd3;

    logic [1:0]          phase_reg, phase_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [63:0]         len_reg, len_next;
    logic [6:0]          octets_reg, octets_next;
    logic [1:0]          class_reg, class_next;
    logic                cons_reg, cons_next;

    logic [1:0]  ph;
    logic        last_byte;
    logic        emit_fail;
    logic [15:0] emit_len_low;
    logic        emit_len_big;
    logic [63:0] tag_wide;

    assign last_byte = (bytes_left == 16'd1);
    assign tag_wide  = 64'(tag_next);

    // Next-state decode of one request
    always_comb
    begin
        phase_next   = phase_reg;
        tag_next     = tag_reg;
        len_next     = len_reg;
        octets_next  = octets_reg;
        class_next   = class_reg;
        cons_next    = cons_reg;
        evt_valid    = 1'b0;
        emit_fail    = 1'b0;
        emit_len_low = 16'd0;
        emit_len_big = 1'b0;
        ph           = restart ? PH_IDLE : phase_reg;

        if (req_valid)
        begin
            phase_next = ph;
            if (bytes_left == 16'd0)
            begin
                // The buffer is already empty: the byte is ignored.
                evt_valid = 1'b1;
                if (ph == PH_IDLE)
                begin
                    class_next = 2'd0;
                    cons_next  = 1'b0;
                    tag_next   = '0;
                    emit_fail  = 1'b1;
                end
                else if (ph == PH_TAG_MORE)
                begin
                    emit_fail = 1'b1;
                end
            end
            else
            begin
                case (ph)
                    PH_IDLE:
                    begin
                        class_next = data_byte[7:6];
                        cons_next  = data_byte[5];
                        tag_next   = TAG_BITS'(data_byte[4:0]);
                        if (data_byte[4:0] != TAG_HIGH_ESCAPE)
                        begin
                            if (last_byte)
                                evt_valid = 1'b1;
                            else
                                phase_next = PH_LEN_FIRST;
                        end
                        else if (last_byte)
                        begin
                            evt_valid = 1'b1;
                            emit_fail = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_TAG_MORE;
                        end
                    end
                    PH_TAG_MORE:
                    begin
                        tag_next = {tag_reg[TAG_BITS-8:0], 7'd0} + TAG_BITS'(data_byte[6:0]);
                        if (data_byte[7])
                        begin
                            if (last_byte)
                            begin
                                evt_valid = 1'b1;
                                emit_fail = 1'b1;
                            end
                        end
                        else if (last_byte)
                        begin
                            evt_valid = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_LEN_FIRST;
                        end
                    end
                    PH_LEN_FIRST:
                    begin
                        if (data_byte[7])
                        begin
                            // Long form; zero octets gives a length of zero.
                            if ((data_byte[6:0] == 7'd0) || last_byte)
                            begin
                                evt_valid = 1'b1;
                            end
                            else
                            begin
                                len_next    = 64'd0;
                                octets_next = data_byte[6:0];
                                phase_next  = PH_LEN_MORE;
                            end
                        end
                        else
                        begin
                            evt_valid    = 1'b1;
                            emit_len_low = {9'd0, data_byte[6:0]};
                        end
                    end
                    default:
                    begin
                        len_next    = {len_reg[55:0], data_byte};
                        octets_next = octets_reg - 7'd1;
                        if (octets_next == 7'd0)
                        begin
                            evt_valid    = 1'b1;
                            emit_len_low = len_next[15:0];
                            emit_len_big = |len_next[63:16];
                        end
                        else if (last_byte)
                        begin
                            evt_valid = 1'b1;
                        end
                    end
                endcase
            end

            // Every finished header sends the decoder back to idle.
            if (evt_valid)
                phase_next = PH_IDLE;
        end
    end

    // Event handed to the queue
    always_comb
    begin
        evt.failed         = emit_fail;
        evt.tag_number     = emit_fail ? 32'd0 : tag_wide[31:0];
        evt.tag_class      = class_next;
        evt.is_constructed = cons_next;
        evt.len_big        = emit_len_big;
        evt.len_low        = emit_len_low;
        evt.remaining      = (bytes_left == 16'd0) ? 16'd0 : bytes_left - 16'd1;
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tag_reg    <= '0;
            len_reg    <= 64'd0;
            octets_reg <= 7'd0;
            class_reg  <= 2'd0;
            cons_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            tag_reg    <= tag_next;
            len_reg    <= len_next;
            octets_reg <= octets_next;
            class_reg  <= class_next;
            cons_reg   <= cons_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dtp_queue.sv
// Short first-in first-out queue of decoded headers between decoder and result stage.
`timescale 1ns / 1ps
`default_nettype none

module dtp_queue
    import dtp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire hdr_event_t  wr_data,
    input  wire logic        rd_en,
    output hdr_event_t       rd_data,
    output q_status_t        status
);

    hdr_event_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_wr, do_rd;

    assign status.full      = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign do_wr   = wr_en && !status.full;
    assign do_rd   = rd_en && status.not_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + QCNT_BITS'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - QCNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

>>> rtl/dtp_back.sv
// Result stage: clamps the length to the bytes left and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module dtp_back
    import dtp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        evt_ready,
    input  wire hdr_event_t  evt,
    output logic             evt_take,
    input  wire logic        pop,
    output logic             out_valid,
    output hdr_result_t      out_data
);

    logic        out_valid_reg, out_valid_next;
    hdr_result_t out_data_reg;
    hdr_result_t res;
    logic        clamp;

    // Clamp the decoded length to the bytes after the header
    always_comb
    begin
        clamp                = evt.len_big || (evt.len_low > evt.remaining);
        res.tag_number       = evt.tag_number;
        res.tag_class        = evt.tag_class;
        res.is_constructed   = evt.is_constructed;
        res.failed           = evt.failed;
        if (evt.failed)
            res.content_length = 16'd0;
        else if (clamp)
            res.content_length = evt.remaining;
        else
            res.content_length = evt.len_low;
    end

    // Load a new result when the register is free or being emptied
    assign evt_take       = evt_ready && (!out_valid_reg || pop);
    assign out_valid_next = evt_take || (out_valid_reg && !pop);
    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
            out_data_reg <= res;
    end

endmodule

`default_nettype wire

>>> rtl/der_tlv_header_parser.sv
// Top level of the DER identifier-and-length header parser.
`timescale 1ns / 1ps
`default_nettype none

// Takes the header bytes of a DER element one per request, each with the count of buffer
// bytes left, and delivers one result request per finished header: tag class, constructed
// flag, tag number, the length clamped to the bytes after the header, and a failure flag
// when the buffer ends inside the tag. One byte is accepted every clock cycle while full is
// low; the decoder hands finished headers to a four-entry queue, after which one result
// register feeds the output, so full rises only once four headers wait in the queue and
// one more in the result register. A finished header passes through the queue and the
// result register before it is on the ports, where it stays until popped. A high tag
// number accumulates modulo 2^TAG_BITS and is reported in its low 32 bits.
module der_tlv_header_parser
    import dtp_pkg::*;
#(
    parameter int TAG_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] bytes_left,
    input  wire logic        restart,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      tag_number,
    output logic [1:0]       tag_class,
    output logic             is_constructed,
    output logic [15:0]      content_length,
    output logic             failed
);

    logic        in_accept;
    logic        evt_valid;
    hdr_event_t  evt_in;
    hdr_event_t  evt_head;
    q_status_t   q_stat;
    logic        evt_take;
    logic        out_valid;
    hdr_result_t out_data;

    assign full      = q_stat.full;
    assign in_accept = push && !q_stat.full;

    // Decoder
    dtp_front #(
        .TAG_BITS (TAG_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (in_accept),
        .data_byte  (data_byte),
        .bytes_left (bytes_left),
        .restart    (restart),
        .evt_valid  (evt_valid),
        .evt        (evt_in)
    );

    // Queue of finished headers
    dtp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (evt_valid),
        .wr_data (evt_in),
        .rd_en   (evt_take),
        .rd_data (evt_head),
        .status  (q_stat)
    );

    // Result stage
    dtp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_ready (q_stat.not_empty),
        .evt       (evt_head),
        .evt_take  (evt_take),
        .pop       (pop),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign empty          = !out_valid;
    assign tag_number     = out_data.tag_number;
    assign tag_class      = out_data.tag_class;
    assign is_constructed = out_data.is_constructed;
    assign content_length = out_data.content_length;
    assign failed         = out_data.failed;

    // A failed header carries neither a tag number nor a length.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && failed) |-> (tag_number == 32'd0 && content_length == 16'd0))
        else $error("failed result carries a tag number or length");

    // The clamp never lets the length reach the full buffer size.
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (content_length != 16'hFFFF))
        else $error("content length exceeds the bytes left after the header");

    // A result only appears when the queue had a header to give.
    a_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> $past(q_stat.not_empty))
        else $error("result appeared without a queued header");

    // A header is written only when the queue can take it.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> !q_stat.full)
        else $error("decoded header written into a full queue");

endmodule

`default_nettype wire

>>> bench/der_hdr_checker.sv
// Checker for the DER header parser: predicts each header result and compares it on delivery.
`timescale 1ns / 1ps

module der_hdr_checker
    import dtp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] bytes_left,
    input  wire logic        restart,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [31:0] tag_number,
    input  wire logic [1:0]  tag_class,
    input  wire logic        is_constructed,
    input  wire logic [15:0] content_length,
    input  wire logic        failed,
    output int               mismatches,
    output int               pending
);

    // Where the decoder stands within the current header.
    typedef enum logic [1:0] {
        AWAIT_ID,
        TAG_MORE,
        LEN_FIRST,
        LEN_MORE
    } parse_phase_t;

    parse_phase_t  ph;
    logic [31:0]   tag_acc;
    logic [63:0]   len_acc;
    logic [6:0]    len_octets;
    logic [1:0]    cls;
    logic          cons;
    hdr_result_t   headers_due[$];

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatches < 40)
        begin
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    // A header has finished: clamp the length to the room after it and queue the result.
    task automatic finish_header(input logic fail, input logic [63:0] len,
                                 input logic [15:0] left);
        logic [63:0] room;
        logic [63:0] clamped;
        hdr_result_t r;
        room    = (left > 16'd0) ? {48'd0, left} - 64'd1 : 64'd0;
        clamped = (len > room) ? room : len;
        r.tag_number     = fail ? 32'd0 : tag_acc;
        r.tag_class      = cls;
        r.is_constructed = cons;
        r.content_length = fail ? 16'd0 : clamped[15:0];
        r.failed         = fail;
        headers_due.push_back(r);
        ph = AWAIT_ID;
    endtask

    // Advances the header decoder by one accepted byte.
    task automatic decode_byte(input logic [7:0] b, input logic [15:0] left, input logic rs);
        if (rs)
        begin
            ph = AWAIT_ID;
        end
        if (left == 16'd0)
        begin
            // The buffer was already empty: the byte only closes what is open.
            if (ph == AWAIT_ID)
            begin
                cls     = 2'd0;
                cons    = 1'b0;
                tag_acc = 32'd0;
                finish_header(1'b1, 64'd0, 16'd0);
            end
            else
            begin
                finish_header(ph == TAG_MORE, 64'd0, 16'd0);
            end
        end
        else
        begin
            case (ph)
                AWAIT_ID:
                begin
                    cls     = b[7:6];
                    cons    = b[5];
                    tag_acc = {27'd0, b[4:0]};
                    if (b[4:0] != TAG_HIGH_ESCAPE)
                    begin
                        if (left == 16'd1)
                            finish_header(1'b0, 64'd0, left);
                        else
                            ph = LEN_FIRST;
                    end
                    else if (left == 16'd1)
                    begin
                        finish_header(1'b1, 64'd0, left);
                    end
                    else
                    begin
                        ph = TAG_MORE;
                    end
                end
                TAG_MORE:
                begin
                    // Base-128 digits; the top bits fall off at 32 bits.
                    tag_acc = {tag_acc[24:0], b[6:0]};
                    if (b[7])
                    begin
                        if (left == 16'd1)
                            finish_header(1'b1, 64'd0, left);
                    end
                    else if (left == 16'd1)
                    begin
                        finish_header(1'b0, 64'd0, left);
                    end
                    else
                    begin
                        ph = LEN_FIRST;
                    end
                end
                LEN_FIRST:
                begin
                    if (b[7])
                    begin
                        if (b[6:0] == 7'd0 || left == 16'd1)
                        begin
                            finish_header(1'b0, 64'd0, left);
                        end
                        else
                        begin
                            len_acc    = 64'd0;
                            len_octets = b[6:0];
                            ph         = LEN_MORE;
                        end
                    end
                    else
                    begin
                        finish_header(1'b0, {57'd0, b[6:0]}, left);
                    end
                end
                default:
                begin
                    len_acc    = {len_acc[55:0], b};
                    len_octets = len_octets - 7'd1;
                    if (len_octets == 7'd0)
                        finish_header(1'b0, len_acc, left);
                    else if (left == 16'd1)
                        finish_header(1'b0, 64'd0, left);
                end
            endcase
        end
    endtask

    // Results are checked before new bytes are decoded; a result never leaves in the
    // cycle that its last byte arrives.
    always @(posedge clk or negedge rst_n)
    begin
        hdr_result_t want;
        if (!rst_n)
        begin
            ph         = AWAIT_ID;
            tag_acc    = 32'd0;
            len_acc    = 64'd0;
            len_octets = 7'd0;
            cls        = 2'd0;
            cons       = 1'b0;
            headers_due.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (headers_due.size() == 0)
                begin
                    report_mismatch("result with no header pending, tag_number",
                                    tag_number, 0);
                end
                else
                begin
                    want = headers_due.pop_front();
                    if (tag_number !== want.tag_number)
                        report_mismatch("tag_number", tag_number, want.tag_number);
                    if (tag_class !== want.tag_class)
                        report_mismatch("tag_class", tag_class, want.tag_class);
                    if (is_constructed !== want.is_constructed)
                        report_mismatch("is_constructed", is_constructed, want.is_constructed);
                    if (content_length !== want.content_length)
                        report_mismatch("content_length", content_length, want.content_length);
                    if (failed !== want.failed)
                        report_mismatch("failed", failed, want.failed);
                end
            end
            if (push && !full)
            begin
                decode_byte(data_byte, bytes_left, restart);
            end
        end
        pending = headers_due.size();
    end

endmodule

>>> bench/tb_top.sv
// Top of the DER header parser testbench: clock, reset, byte stimulus and the verdict.
`timescale 1ns / 1ps

module tb_top;
    import dtp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 600;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'd0;
    logic [15:0] bytes_left = 16'd0;
    logic        restart = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] tag_number;
    logic [1:0]  tag_class;
    logic        is_constructed;
    logic [15:0] content_length;
    logic        failed;

    int          mismatches;
    int          pending;
    int          cycles = 0;
    int          bytes_sent = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    logic [7:0]  header_bytes[$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    der_tlv_header_parser uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .bytes_left     (bytes_left),
        .restart        (restart),
        .empty          (empty),
        .pop            (pop),
        .tag_number     (tag_number),
        .tag_class      (tag_class),
        .is_constructed (is_constructed),
        .content_length (content_length),
        .failed         (failed)
    );

    der_hdr_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .bytes_left     (bytes_left),
        .restart        (restart),
        .empty          (empty),
        .pop            (pop),
        .tag_number     (tag_number),
        .tag_class      (tag_class),
        .is_constructed (is_constructed),
        .content_length (content_length),
        .failed         (failed),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    // The result side stalls at random according to the current phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one byte request, after a random gap, and waits until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic [15:0] left, input logic rs);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        data_byte  <= b;
        bytes_left <= left;
        restart    <= rs;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Builds a well-formed header with random content, then streams it against a
    // buffer size that sometimes cuts it short.
    task automatic random_header();
        logic [7:0] b;
        int         n_cont;
        int         octs;
        int         pick;
        int         buf_len;
        int         i;
        logic       rs;
        header_bytes.delete();

        // Identifier byte, a third of them with a high tag number.
        b = 8'($urandom);
        if ($urandom_range(0, 99) < 35)
            b[4:0] = TAG_HIGH_ESCAPE;
        else if (b[4:0] == TAG_HIGH_ESCAPE)
            b[4:0] = 5'($urandom_range(0, 30));
        header_bytes.push_back(b);
        if (b[4:0] == TAG_HIGH_ESCAPE)
        begin
            n_cont = $urandom_range(1, 6);
            for (i = 0; i < n_cont; i++)
            begin
                b    = 8'($urandom);
                b[7] = (i != n_cont - 1);
                header_bytes.push_back(b);
            end
        end

        // Length in short form or long form, including zero and oversized octet counts.
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            b    = 8'($urandom);
            b[7] = 1'b0;
            header_bytes.push_back(b);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                octs = 0;
            else if (pick < 80)
                octs = $urandom_range(1, 4);
            else if (pick < 97)
                octs = $urandom_range(5, 9);
            else
                octs = $urandom_range(10, 127);
            header_bytes.push_back({1'b1, octs[6:0]});
            for (i = 0; i < octs; i++)
                header_bytes.push_back(8'($urandom));
        end

        // Buffer size: mostly room to spare, sometimes truncating, sometimes anything.
        pick = $urandom_range(0, 99);
        if (pick < 40)
            buf_len = header_bytes.size() + $urandom_range(0, 300);
        else if (pick < 60)
            buf_len = $urandom_range(1, header_bytes.size());
        else if (pick < 90)
            buf_len = $urandom_range(1, 65535);
        else
            buf_len = $urandom_range(1, 3);

        // Occasionally a stray byte first, to leave the decoder mid-header.
        if ($urandom_range(0, 99) < 6)
            send_byte(8'($urandom), 16'($urandom_range(1, 65535)),
                      1'($urandom_range(0, 1)));

        rs = 1'($urandom_range(0, 1));
        for (i = 0; i < header_bytes.size() && buf_len - i >= 1; i++)
        begin
            if ($urandom_range(0, 99) < 2)
            begin
                send_byte(header_bytes[i], 16'd0, 1'b0);
                break;
            end
            send_byte(header_bytes[i], 16'(buf_len - i),
                      (i == 0) ? rs : ($urandom_range(0, 99) < 2));
        end
    endtask

    initial
    begin
        int first_random;
        int stage;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed headers, with no idling on either side.
        // Largest short-form length with plenty of room.
        send_byte(8'hFE, 16'd200, 1'b1);
        send_byte(8'h7F, 16'd199, 1'b0);
        // High tag number, long-form 0xFFFF length clamped, full buffer size.
        send_byte(8'hFF, 16'd65535, 1'b0);
        send_byte(8'h81, 16'd65534, 1'b0);
        send_byte(8'h7F, 16'd65533, 1'b0);
        send_byte(8'h82, 16'd65532, 1'b0);
        send_byte(8'hFF, 16'd65531, 1'b0);
        send_byte(8'hFF, 16'd65530, 1'b0);
        // All-zero identifier with a long form of zero octets.
        send_byte(8'h00, 16'd10, 1'b0);
        send_byte(8'h80, 16'd9, 1'b0);
        // Buffer ends right after an identifier that asks for a high tag number.
        send_byte(8'h1F, 16'd1, 1'b0);
        // Buffer ends on a continuation byte of the tag.
        send_byte(8'h5F, 16'd3, 1'b0);
        send_byte(8'h85, 16'd2, 1'b0);
        send_byte(8'h85, 16'd1, 1'b0);
        // Tag completes on the last byte of the buffer.
        send_byte(8'h30, 16'd1, 1'b0);
        // Long-form length cut short by the buffer.
        send_byte(8'h04, 16'd3, 1'b0);
        send_byte(8'h82, 16'd2, 1'b0);
        send_byte(8'h01, 16'd1, 1'b0);
        // Empty buffer while idle, then inside the tag.
        send_byte(8'hAB, 16'd0, 1'b0);
        send_byte(8'h1F, 16'd5, 1'b0);
        send_byte(8'h00, 16'd0, 1'b0);
        // Restart in the middle of a length, then an empty buffer inside the new length.
        send_byte(8'h04, 16'd9, 1'b0);
        send_byte(8'h81, 16'd8, 1'b0);
        send_byte(8'h02, 16'd7, 1'b1);
        send_byte(8'h83, 16'd6, 1'b0);
        send_byte(8'h00, 16'd0, 1'b0);

        // Random headers across the idling phases.
        first_random = bytes_sent;
        while (bytes_sent - first_random < RANDOM_BYTES)
        begin
            stage = (bytes_sent - first_random) / (RANDOM_BYTES / 4);
            case (stage)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 62;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 62;
                end
                default:
                begin
                    gap_pct   = 16;
                    stall_pct = 16;
                end
            endcase
            random_header();
        end
        push <= 1'b0;

        // Drain the results, then watch a little longer for strays.
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
